### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcpop_pkg.sv
// types and constants of the tcp option parser
// no dependencies
`timescale 1ns / 1ps

package tcpop_pkg;

   localparam logic [7:0] OPT_KIND_END    = 8'd0;
   localparam logic [7:0] OPT_KIND_NOP    = 8'd1;
   localparam logic [7:0] OPT_KIND_MSS    = 8'd2;
   localparam logic [7:0] OPT_KIND_WSCALE = 8'd3;
   localparam logic [7:0] WSCALE_LIMIT    = 8'd14;
   localparam logic [5:0] MSS_OPT_LEN     = 6'd4;
   localparam logic [5:0] WSCALE_OPT_LEN  = 6'd3;
   localparam logic [7:0] MIN_OPT_LEN     = 8'd2;

   localparam logic [4:0] HDR_OFFSET_POS = 5'd12;
   localparam logic [4:0] HDR_LAST_POS   = 5'd19;
   localparam logic [5:0] HDR_BASE_LEN   = 6'd20;

   // skip counter marks for the length byte of mss and window scale
   localparam logic [5:0] MARK_MSS = 6'd62;
   localparam logic [5:0] MARK_WS  = 6'd63;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_OPT  = 2'd1,
      ST_BAD_LEN = 2'd2,
      ST_EARLY   = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      PH_IDLE  = 8'b0000_0001,
      PH_HDR   = 8'b0000_0010,
      PH_KIND  = 8'b0000_0100,
      PH_LEN   = 8'b0000_1000,
      PH_SKIP  = 8'b0001_0000,
      PH_MSSHI = 8'b0010_0000,
      PH_MSSLO = 8'b0100_0000,
      PH_WSVAL = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        done_res;
      status_type  status;
      logic        mss_seen;
      logic [15:0] mss_value;
      logic        wscale_seen;
      logic [3:0]  wscale_value;
   } result_type;

endpackage

### src/tcp_option_parser_unit.sv
// top level of the tcp option parser: option walk, mss rewrite, result buffer
// depends on tcpop_pkg
//
//   channel | ports                        | role
//   req     | req_valid, req_stall, req_*  | header bytes in, one beat per byte
//   rsp     | rsp_valid, rsp_stall, rsp_*  | byte out plus verdict, one beat per byte
//   csr     | csr_wr_en, csr_wr_data       | mss rewrite value
//
// one beat in per cycle unless req_stall; results go to output register or skid
// the option walk updates its registered state from each accepted byte
// a two-entry output buffer (output register plus skid) keeps req open while
// one result waits; req_stall rises only when both entries are full
// synchronous reset clears the walk, the rewrite register and the buffer
`timescale 1ns / 1ps

module tcp_option_parser_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_first_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_done_res,
   output tcpop_pkg::status_type    rsp_status,
   output logic                     rsp_mss_seen,
   output logic [15:0]              rsp_mss_value,
   output logic                     rsp_wscale_seen,
   output logic [3:0]               rsp_wscale_value,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data
);
   import tcpop_pkg::*;

   logic [15:0] mss_rewrite_ff;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [5:0]  opt_left_ff, opt_left_in;
   logic [5:0]  skip_ff, skip_in;
   logic [15:0] mss_accum_ff, mss_accum_in;
   logic        mss_found_ff, mss_found_in;
   logic [3:0]  wscale_ff, wscale_in;
   logic        wscale_found_ff, wscale_found_in;

   result_type  res_in;
   result_type  out_ff;
   result_type  skid_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;

   logic        accept;
   logic        out_take;
   logic        fin_done;
   status_type  fin_status;
   logic [7:0]  ob;
   logic [5:0]  hdr_len;
   logic [5:0]  consumed;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;
   assign hdr_len  = {req_data_byte[7:4], 2'b00};

   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      opt_left_in     = opt_left_ff;
      skip_in         = skip_ff;
      mss_accum_in    = mss_accum_ff;
      mss_found_in    = mss_found_ff;
      wscale_in       = wscale_ff;
      wscale_found_in = wscale_found_ff;
      fin_done        = 1'b0;
      fin_status      = ST_OK;
      ob              = req_data_byte;
      consumed        = '0;

      if (req_first_byte) begin
         phase_in        = PH_HDR;
         pos_in          = '0;
         opt_left_in     = '0;
         skip_in         = '0;
         mss_accum_in    = '0;
         mss_found_in    = 1'b0;
         wscale_in       = '0;
         wscale_found_in = 1'b0;
      end

      case (phase_in)
         PH_HDR: begin
            if (pos_in == HDR_OFFSET_POS && hdr_len <= HDR_BASE_LEN) begin
               fin_done   = 1'b1;
               fin_status = ST_NO_OPT;
               phase_in   = PH_IDLE;
            end else begin
               if (pos_in == HDR_OFFSET_POS) begin
                  opt_left_in = hdr_len - HDR_BASE_LEN;
               end
               if (pos_in >= HDR_LAST_POS) begin
                  phase_in = PH_KIND;
               end else begin
                  pos_in = pos_in + 5'd1;
               end
            end
         end
         PH_KIND: begin
            if (req_data_byte == OPT_KIND_END) begin
               fin_done = 1'b1;
               phase_in = PH_IDLE;
            end else if (req_data_byte == OPT_KIND_NOP) begin
               consumed = 6'd1;
            end else if (req_data_byte == OPT_KIND_MSS) begin
               skip_in  = MARK_MSS;
               phase_in = PH_LEN;
            end else if (req_data_byte == OPT_KIND_WSCALE) begin
               skip_in  = MARK_WS;
               phase_in = PH_LEN;
            end else begin
               skip_in  = '0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (skip_in == MARK_MSS) begin
               phase_in = PH_MSSHI;
            end else if (skip_in == MARK_WS) begin
               phase_in = PH_WSVAL;
            end else if (req_data_byte < MIN_OPT_LEN
                         || req_data_byte > {2'b00, opt_left_in}) begin
               fin_done   = 1'b1;
               fin_status = ST_BAD_LEN;
               phase_in   = PH_IDLE;
            end else begin
               opt_left_in = opt_left_in - req_data_byte[5:0];
               if (opt_left_in == '0) begin
                  fin_done = 1'b1;
                  phase_in = PH_IDLE;
               end else if (req_data_byte == MIN_OPT_LEN) begin
                  phase_in = PH_KIND;
               end else begin
                  skip_in  = req_data_byte[5:0] - MIN_OPT_LEN[5:0];
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (skip_in <= 6'd1) begin
               skip_in  = '0;
               phase_in = PH_KIND;
            end else begin
               skip_in = skip_in - 6'd1;
            end
         end
         PH_MSSHI: begin
            if (mss_rewrite_ff != '0) begin
               ob = mss_rewrite_ff[15:8];
            end
            mss_accum_in = {ob, 8'h00};
            phase_in     = PH_MSSLO;
         end
         PH_MSSLO: begin
            if (mss_rewrite_ff != '0) begin
               ob           = mss_rewrite_ff[7:0];
               mss_accum_in = mss_rewrite_ff;
            end else begin
               mss_accum_in = {mss_accum_in[15:8], req_data_byte};
            end
            mss_found_in = 1'b1;
            consumed     = MSS_OPT_LEN;
         end
         PH_WSVAL: begin
            wscale_in       = (req_data_byte > WSCALE_LIMIT) ?
                              WSCALE_LIMIT[3:0] : req_data_byte[3:0];
            wscale_found_in = 1'b1;
            consumed        = WSCALE_OPT_LEN;
         end
         default: begin
         end
      endcase

      // option fully taken: count down the bytes left, saturating
      if (consumed != '0) begin
         opt_left_in = (opt_left_in > consumed) ? (opt_left_in - consumed) : '0;
         if (opt_left_in == '0) begin
            fin_done = 1'b1;
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_KIND;
         end
      end

      if (!fin_done && phase_in != PH_IDLE && req_last_byte) begin
         fin_done   = 1'b1;
         fin_status = ST_EARLY;
         phase_in   = PH_IDLE;
      end

      res_in.out_byte     = ob;
      res_in.done_res     = fin_done;
      res_in.status       = fin_done ? fin_status : ST_OK;
      res_in.mss_seen     = fin_done && mss_found_in;
      res_in.mss_value    = (fin_done && mss_found_in) ? mss_accum_in : '0;
      res_in.wscale_seen  = fin_done && wscale_found_in;
      res_in.wscale_value = (fin_done && wscale_found_in) ? wscale_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mss_rewrite_ff <= '0;
      end else if (csr_wr_en) begin
         mss_rewrite_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pos_ff          <= '0;
         opt_left_ff     <= '0;
         skip_ff         <= '0;
         mss_accum_ff    <= '0;
         mss_found_ff    <= 1'b0;
         wscale_ff       <= '0;
         wscale_found_ff <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         opt_left_ff     <= opt_left_in;
         skip_ff         <= skip_in;
         mss_accum_ff    <= mss_accum_in;
         mss_found_ff    <= mss_found_in;
         wscale_ff       <= wscale_in;
         wscale_found_ff <= wscale_found_in;
      end
   end

   // output register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_done_res     = out_ff.done_res;
   assign rsp_status       = out_ff.status;
   assign rsp_mss_seen     = out_ff.mss_seen;
   assign rsp_mss_value    = out_ff.mss_value;
   assign rsp_wscale_seen  = out_ff.wscale_seen;
   assign rsp_wscale_value = out_ff.wscale_value;

endmodule

### src/tcpop_checker.sv
// port-level checks for the tcp option parser, bound to the top level
// depends on tcpop_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpop_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_out_byte,
   input logic                  rsp_done_res,
   input tcpop_pkg::status_type rsp_status,
   input logic                  rsp_mss_seen,
   input logic [15:0]           rsp_mss_value,
   input logic                  rsp_wscale_seen,
   input logic [3:0]            rsp_wscale_value
);
   import tcpop_pkg::*;

   logic [32:0] rsp_beat;
   logic        rsp_wait;
   logic        req_take;
   logic        rsp_plain;
   logic        verdict_quiet;
   logic        values_in_range;

   assign rsp_beat  = {rsp_out_byte, rsp_done_res, rsp_status, rsp_mss_seen,
                       rsp_mss_value, rsp_wscale_seen, rsp_wscale_value};
   assign rsp_wait  = rsp_valid && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_plain = rsp_valid && !rsp_done_res;
   assign verdict_quiet = rsp_status == ST_OK && !rsp_mss_seen && !rsp_wscale_seen
                          && rsp_mss_value == 16'd0 && rsp_wscale_value == 4'd0;
   assign values_in_range = rsp_wscale_value <= WSCALE_LIMIT[3:0]
                            && (rsp_wscale_seen || rsp_wscale_value == 4'd0)
                            && (rsp_mss_seen || rsp_mss_value == 16'd0);

   // stalled beat holds
   `ASSERT_CLK(a_hold, clock, reset, rsp_wait |=> rsp_valid && $stable(rsp_beat), "beat moved")
   // input is only held off when a result is already waiting
   `ASSERT_CLK(a_stall_needs_rsp, clock, reset, req_stall |-> rsp_valid, "stall without result")
   // after every accepted beat the output holds a valid result next cycle
   `ASSERT_CLK(a_accept_to_rsp, clock, reset, req_take |=> rsp_valid, "beat gave no result")
   // verdict fields are quiet when no verdict is given
   `ASSERT_CLK(a_quiet_fields, clock, reset, rsp_plain |-> verdict_quiet, "verdict fields set")
   // window shift clamped; window shift and mss value zero when not seen
   `ASSERT_CLK(a_wscale_range, clock, reset, rsp_valid |-> values_in_range, "value out of range")

endmodule

bind tcp_option_parser_unit tcpop_checker u_tcpop_checker (.*);
